### sv/hcs_pkg.sv
// hcs_pkg: shared types and constants for the heightmap contrast stretch core
// transaction structs, mode codes, sequencer states and shading constants
// no dependencies
package hcs_pkg;

    localparam int HEIGHT_BITS = 12;
    localparam int COORD_BITS  = 9;
    localparam int SHADE_BITS  = 8;
    localparam int QUOT_STEPS  = 8;
    localparam int STEP_BITS   = 3;
    localparam int EPOCH_BITS  = 3;

    localparam logic [1:0] MODE_LOAD   = 2'd0;
    localparam logic [1:0] MODE_READ   = 2'd1;
    localparam logic [1:0] MODE_REGION = 2'd2;

    localparam logic [SHADE_BITS-1:0] SHADE_BASE  = 8'd40;
    localparam logic [SHADE_BITS-1:0] SHADE_RANGE = 8'd215;
    localparam logic [SHADE_BITS-1:0] BG_RED      = 8'd16;
    localparam logic [SHADE_BITS-1:0] BG_GREEN    = 8'd16;
    localparam logic [SHADE_BITS-1:0] BG_BLUE     = 8'd24;

    localparam logic [EPOCH_BITS-1:0] EPOCH_FIRST = 3'd1;
    localparam logic [EPOCH_BITS-1:0] EPOCH_LAST  = 3'd7;

    typedef struct packed {
        logic [1:0]                    mode;
        logic [COORD_BITS-1:0]         pos_x;
        logic [COORD_BITS-1:0]         pos_z;
        logic signed [HEIGHT_BITS-1:0] height;
    } t_in_item;

    typedef struct packed {
        logic [SHADE_BITS-1:0] red;
        logic [SHADE_BITS-1:0] green;
        logic [SHADE_BITS-1:0] blue;
        logic                  covered;
    } t_out_item;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOOK,
        ST_SCALE,
        ST_DIV,
        ST_DONE
    } t_state;

endpackage

### sv/heightmap_contrast_stretch_core.sv
// heightmap_contrast_stretch_core: column height grid with min/max grey stretch
// holds the height memory, running extremes and a restoring divider
// depends on hcs_pkg
//
// A load transaction writes one column height into a GRID_SIZE x GRID_SIZE memory and widens
// the running lowest/highest heights; it gives no result. A new-region transaction forgets
// all columns and extremes by advancing a 3-bit epoch tag kept with every memory word; every
// seventh region instead runs a clearing pass over all GRID_SIZE*GRID_SIZE words, and the same
// pass runs once after reset, during which o_in_stall stays high. For a read transaction the
// memory is read at the accepting edge, then span and offset are formed, the offset is
// multiplied by 215, the restoring divider runs (one quotient bit per cycle, quotient never
// exceeds 215) and the result is handed over to the output register once that is free; a
// read of an absent column goes straight from the lookup to the hand-over. The input is free
// again once the result has landed. The output register lets the next transaction be accepted
// while a result is still stalled. Absent or off-grid columns give the background colour
// 16,16,24 with covered low.
module heightmap_contrast_stretch_core
    import hcs_pkg::*;
#(
    parameter int GRID_SIZE = 512
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in_item,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_item
);

    localparam int CELLS = GRID_SIZE * GRID_SIZE;
    localparam int AW    = $clog2(CELLS);
    localparam int MW    = EPOCH_BITS + HEIGHT_BITS;
    localparam int HB    = HEIGHT_BITS;

    localparam logic signed [HB-1:0] HMAX = {1'b0, {(HB-1){1'b1}}};
    localparam logic signed [HB-1:0] HMIN = {1'b1, {(HB-1){1'b0}}};

    // height memory: {epoch tag, height}
    logic [MW-1:0] r_mem [CELLS];
    logic [MW-1:0] r_rd_data;

    // control state
    t_state                 r_state, n_state;
    logic [EPOCH_BITS-1:0]  r_epoch, n_epoch;
    logic [AW-1:0]          r_clr_addr, n_clr_addr;
    logic signed [HB-1:0]   r_low, n_low;
    logic signed [HB-1:0]   r_high, n_high;
    logic                   r_out_valid, n_out_valid;
    logic [STEP_BITS-1:0]   r_step, n_step;

    // datapath
    logic                   r_inside, n_inside;
    logic [HB-1:0]          r_span, n_span;
    logic [HB-1:0]          r_off, n_off;
    logic [HB-1:0]          r_rem, n_rem;
    logic [SHADE_BITS-1:0]  r_num_lo, n_num_lo;
    logic [SHADE_BITS-1:0]  r_quot, n_quot;
    t_out_item              r_res, n_res;
    t_out_item              r_out_item, n_out_item;

    logic                   w_accept;
    logic                   w_inside;
    logic [AW-1:0]          w_idx;
    logic                   w_we;
    logic [AW-1:0]          w_waddr;
    logic [MW-1:0]          w_wdata;

    logic signed [HB:0]     w_h, w_lo, w_hi, w_diff, w_range;
    logic                   w_present;
    logic [HB-1:0]          w_span, w_off;
    logic [HB+7:0]          w_prod;
    logic [HB:0]            w_trial, w_sub;
    logic                   w_ge;

    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    assign w_accept = i_in_valid && !o_in_stall;
    assign w_inside = (32'(i_in_item.pos_x) < GRID_SIZE) && (32'(i_in_item.pos_z) < GRID_SIZE);
    assign w_idx    = AW'(32'(i_in_item.pos_z) * GRID_SIZE + 32'(i_in_item.pos_x));

    // single write port: clearing pass or column load
    always_comb begin
        w_we    = 1'b0;
        w_waddr = w_idx;
        w_wdata = {r_epoch, i_in_item.height};
        if (r_state == ST_CLEAR) begin
            w_we    = 1'b1;
            w_waddr = r_clr_addr;
            w_wdata = '0;
        end else if (w_accept && i_in_item.mode == MODE_LOAD && w_inside) begin
            w_we = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_data <= r_mem[w_idx];
    end

    // span and clamped offset from the looked-up column
    assign w_h       = {r_rd_data[HB-1], r_rd_data[HB-1:0]};
    assign w_lo      = {r_low[HB-1], r_low};
    assign w_hi      = {r_high[HB-1], r_high};
    assign w_range   = w_hi - w_lo;
    assign w_diff    = w_h - w_lo;
    assign w_present = r_inside && (r_rd_data[MW-1:HB] == r_epoch);

    always_comb begin
        w_span = (w_hi > w_lo) ? w_range[HB-1:0] : HB'(1);
        w_off  = (w_h > w_lo) ? w_diff[HB-1:0] : '0;
        if (w_off > w_span) begin
            w_off = w_span;
        end
    end

    assign w_prod  = (HB+8)'(r_off) * (HB+8)'(SHADE_RANGE);

    // one restoring step; remainder always stays below the span
    assign w_trial = {r_rem, r_num_lo[SHADE_BITS-1]};
    assign w_ge    = (w_trial >= {1'b0, r_span});
    assign w_sub   = w_trial - {1'b0, r_span};

    always_comb begin
        n_state     = r_state;
        n_epoch     = r_epoch;
        n_clr_addr  = r_clr_addr;
        n_low       = r_low;
        n_high      = r_high;
        n_out_valid = r_out_valid && i_out_stall;
        n_step      = r_step;
        n_inside    = r_inside;
        n_span      = r_span;
        n_off       = r_off;
        n_rem       = r_rem;
        n_num_lo    = r_num_lo;
        n_quot      = r_quot;
        n_res       = r_res;
        n_out_item  = r_out_item;

        unique case (r_state)
            ST_CLEAR: begin
                n_clr_addr = r_clr_addr + AW'(1);
                if (r_clr_addr == AW'(CELLS - 1)) begin
                    n_clr_addr = '0;
                    n_state    = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (w_accept) begin
                    unique case (i_in_item.mode)
                        MODE_LOAD: begin
                            if (w_inside) begin
                                if (i_in_item.height < r_low) begin
                                    n_low = i_in_item.height;
                                end
                                if (i_in_item.height > r_high) begin
                                    n_high = i_in_item.height;
                                end
                            end
                        end
                        MODE_READ: begin
                            n_inside = w_inside;
                            n_state  = ST_LOOK;
                        end
                        MODE_REGION: begin
                            n_low  = HMAX;
                            n_high = HMIN;
                            if (r_epoch == EPOCH_LAST) begin
                                // tags would wrap: wipe the memory instead
                                n_epoch    = EPOCH_FIRST;
                                n_clr_addr = '0;
                                n_state    = ST_CLEAR;
                            end else begin
                                n_epoch = r_epoch + EPOCH_BITS'(1);
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_LOOK: begin
                if (w_present) begin
                    n_span  = w_span;
                    n_off   = w_off;
                    n_state = ST_SCALE;
                end else begin
                    n_res   = '{red: BG_RED, green: BG_GREEN, blue: BG_BLUE, covered: 1'b0};
                    n_state = ST_DONE;
                end
            end
            ST_SCALE: begin
                // quotient fits 8 bits, so the upper product bits seed the remainder
                n_rem    = w_prod[HB+7:SHADE_BITS];
                n_num_lo = w_prod[SHADE_BITS-1:0];
                n_step   = '0;
                n_state  = ST_DIV;
            end
            ST_DIV: begin
                n_rem    = w_ge ? w_sub[HB-1:0] : w_trial[HB-1:0];
                n_num_lo = {r_num_lo[SHADE_BITS-2:0], 1'b0};
                n_quot   = {r_quot[SHADE_BITS-2:0], w_ge};
                n_step   = r_step + STEP_BITS'(1);
                if (r_step == STEP_BITS'(QUOT_STEPS - 1)) begin
                    n_res.red     = SHADE_BASE + {r_quot[SHADE_BITS-2:0], w_ge};
                    n_res.green   = SHADE_BASE + {r_quot[SHADE_BITS-2:0], w_ge};
                    n_res.blue    = SHADE_BASE + {r_quot[SHADE_BITS-2:0], w_ge};
                    n_res.covered = 1'b1;
                    n_state       = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out_item  = r_res;
                    n_out_valid = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_epoch     <= EPOCH_FIRST;
            r_clr_addr  <= '0;
            r_low       <= HMAX;
            r_high      <= HMIN;
            r_out_valid <= 1'b0;
            r_step      <= '0;
        end else begin
            r_state     <= n_state;
            r_epoch     <= n_epoch;
            r_clr_addr  <= n_clr_addr;
            r_low       <= n_low;
            r_high      <= n_high;
            r_out_valid <= n_out_valid;
            r_step      <= n_step;
        end
    end

    always_ff @(posedge i_clk) begin
        r_inside   <= n_inside;
        r_span     <= n_span;
        r_off      <= n_off;
        r_rem      <= n_rem;
        r_num_lo   <= n_num_lo;
        r_quot     <= n_quot;
        r_res      <= n_res;
        r_out_item <= n_out_item;
    end

    // epoch zero marks cleared words, so it must never be the live epoch
    a_epoch_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_epoch != '0)
        else $error("live epoch is zero");

    // divider invariant: partial remainder below the span
    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_DIV |-> r_rem < r_span)
        else $error("divider remainder out of range");

    // an in-grid load leaves the extremes ordered
    a_extremes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_in_item.mode == MODE_LOAD && w_inside) |=> r_low <= r_high)
        else $error("extremes out of order after load");

    // a new result only appears from the hand-over state
    a_result_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !$past(o_out_valid && i_out_stall)) |-> $past(r_state == ST_DONE))
        else $error("result without a finished read");

endmodule

### tb/hcs_stretch_checker.sv
`timescale 1ns / 1ps
// hcs_stretch_checker: watches both channels of the contrast stretch core and scores results
// keeps its own column grid and height extremes to predict every pixel, depends on hcs_pkg
module hcs_stretch_checker
    import hcs_pkg::*;
#(
    parameter int GRID_SIZE = 512
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    input  logic      i_in_stall,
    input  t_in_item  i_in_item,
    input  logic      i_out_valid,
    input  logic      i_out_stall,
    input  t_out_item i_out_item,
    output int        o_errors,
    output int        o_pending
);

    localparam logic signed [HEIGHT_BITS-1:0] HEIGHT_TOP    = {1'b0, {(HEIGHT_BITS-1){1'b1}}};
    localparam logic signed [HEIGHT_BITS-1:0] HEIGHT_BOTTOM = {1'b1, {(HEIGHT_BITS-1){1'b0}}};

    logic signed [HEIGHT_BITS-1:0] column_height [int];
    bit                            column_present [int];
    logic signed [HEIGHT_BITS-1:0] lowest_h;
    logic signed [HEIGHT_BITS-1:0] highest_h;
    t_out_item                     pixel_queue [$];
    int                            error_count;

    function automatic t_out_item shade_pixel(input t_in_item it);
        t_out_item px;
        int        spot;
        int        h;
        int        span;
        int        offset;
        px.red     = BG_RED;
        px.green   = BG_GREEN;
        px.blue    = BG_BLUE;
        px.covered = 1'b0;
        if (int'(it.pos_x) < GRID_SIZE && int'(it.pos_z) < GRID_SIZE) begin
            spot = int'(it.pos_z) * GRID_SIZE + int'(it.pos_x);
            if (column_present.exists(spot)) begin
                h      = int'(column_height[spot]);
                span   = int'(highest_h) - int'(lowest_h);
                if (span <= 0) span = 1;
                offset = h - int'(lowest_h);
                if (offset < 0) offset = 0;
                if (offset > span) offset = span;
                px.red     = SHADE_BITS'(int'(SHADE_BASE) + offset * int'(SHADE_RANGE) / span);
                px.green   = px.red;
                px.blue    = px.red;
                px.covered = 1'b1;
            end
        end
        return px;
    endfunction

    function automatic int field_diff(input string name, input logic [SHADE_BITS-1:0] want,
                                      input logic [SHADE_BITS-1:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            return 1;
        end
        return 0;
    endfunction

    always @(posedge i_clk) begin : watch
        t_out_item want;
        int        spot;
        if (!i_rst_n) begin
            column_present.delete();
            column_height.delete();
            pixel_queue.delete();
            lowest_h  = HEIGHT_TOP;
            highest_h = HEIGHT_BOTTOM;
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (pixel_queue.size() == 0) begin
                    $error("pixel result with none pending: red %0d green %0d blue %0d covered %0d",
                           i_out_item.red, i_out_item.green, i_out_item.blue,
                           i_out_item.covered);
                    error_count++;
                end else begin
                    want = pixel_queue.pop_front();
                    error_count += field_diff("red", want.red, i_out_item.red);
                    error_count += field_diff("green", want.green, i_out_item.green);
                    error_count += field_diff("blue", want.blue, i_out_item.blue);
                    error_count += field_diff("covered", SHADE_BITS'(want.covered),
                                              SHADE_BITS'(i_out_item.covered));
                end
            end
            if (i_in_valid && !i_in_stall) begin
                case (i_in_item.mode)
                    MODE_LOAD: begin
                        if (int'(i_in_item.pos_x) < GRID_SIZE && int'(i_in_item.pos_z) < GRID_SIZE)
                        begin
                            spot = int'(i_in_item.pos_z) * GRID_SIZE + int'(i_in_item.pos_x);
                            column_height[spot]  = i_in_item.height;
                            column_present[spot] = 1'b1;
                            if (i_in_item.height < lowest_h) lowest_h = i_in_item.height;
                            if (i_in_item.height > highest_h) highest_h = i_in_item.height;
                        end
                    end
                    MODE_READ: begin
                        pixel_queue.push_back(shade_pixel(i_in_item));
                    end
                    MODE_REGION: begin
                        column_present.delete();
                        lowest_h  = HEIGHT_TOP;
                        highest_h = HEIGHT_BOTTOM;
                    end
                    default: begin
                    end
                endcase
            end
        end
        o_errors  <= error_count;
        o_pending <= pixel_queue.size();
    end

endmodule

### tb/tb_top.sv
`timescale 1ns / 1ps
// tb_top: stimulus and verdict for heightmap_contrast_stretch_core
// drives load, read and new-region transactions, depends on hcs_pkg and hcs_stretch_checker
module tb_top;
    import hcs_pkg::*;

    localparam int         GRID_SIZE    = 512;
    localparam logic [1:0] MODE_UNUSED  = 2'd3;
    localparam int         RANDOM_ITEMS = 1950;
    localparam int         POOL_MAX     = 48;
    // give the read path plenty of slack
    localparam int         TAIL_CYCLES  = 40;
    // clearing passes after reset and on every seventh region,
    // plus worst-case gaps and stalls per transaction, taken several times over
    localparam int         RUN_LIMIT_NS = 50_000_000;

    logic      clk;
    logic      rst_n;
    logic      in_valid;
    logic      in_stall;
    t_in_item  in_item;
    logic      out_valid;
    logic      out_stall;
    t_out_item out_item;
    int        errors;
    int        pending;

    // idling knobs, switched between stretches of transactions
    bit        gaps_on;
    bit        stalls_on;

    // coordinates loaded in the current region, packed as {x, z}
    logic [2*COORD_BITS-1:0]       coord_pool [$];
    // wide regions use the full height range, narrow ones a small band
    bit                            wide_heights;
    logic signed [HEIGHT_BITS-1:0] height_base;

    heightmap_contrast_stretch_core #(
        .GRID_SIZE(GRID_SIZE)
    ) i_dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .o_in_stall (in_stall),
        .i_in_item  (in_item),
        .o_out_valid(out_valid),
        .i_out_stall(out_stall),
        .o_out_item (out_item)
    );

    hcs_stretch_checker #(
        .GRID_SIZE(GRID_SIZE)
    ) u_checker (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .i_in_stall (in_stall),
        .i_in_item  (in_item),
        .i_out_valid(out_valid),
        .i_out_stall(out_stall),
        .i_out_item (out_item),
        .o_errors   (errors),
        .o_pending  (pending)
    );

    always begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // mostly short gaps, now and then a long one
    function automatic int gap_len();
        if ($urandom_range(0, 99) < 85) return $urandom_range(0, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic t_in_item make_item(input logic [1:0] mode,
                                           input logic [COORD_BITS-1:0] x,
                                           input logic [COORD_BITS-1:0] z,
                                           input logic signed [HEIGHT_BITS-1:0] h);
        t_in_item it;
        it.mode   = mode;
        it.pos_x  = x;
        it.pos_z  = z;
        it.height = h;
        return it;
    endfunction

    function automatic logic signed [HEIGHT_BITS-1:0] pick_height();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 8) begin
            // full-scale and sign-boundary heights
            case ($urandom_range(0, 3))
                0:       return 12'sh800;
                1:       return 12'sh7FF;
                2:       return 12'sh000;
                default: return 12'shFFF;
            endcase
        end
        if (wide_heights) return HEIGHT_BITS'($urandom);
        return height_base + HEIGHT_BITS'($urandom_range(0, 15));
    endfunction

    // drop valid for a pause of length n, nothing happens for n == 0 so valid stays high
    task automatic pause_sender(input int n);
        if (n > 0) begin
            in_valid <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    // present one transaction and hold it until the core takes it
    task automatic send_item(input t_in_item it);
        in_valid <= 1'b1;
        in_item  <= it;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        if (gaps_on) pause_sender(gap_len());
    endtask

    // stop sending until every pending pixel has come back
    task automatic drain_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
    endtask

    // sink side: random stall bursts while stalls_on is set
    initial begin : sink_side
        int n;
        out_stall <= 1'b0;
        forever begin
            @(posedge clk);
            if (stalls_on && $urandom_range(0, 5) == 0) begin
                out_stall <= 1'b1;
                n = 1 + gap_len();
                repeat (n) @(posedge clk);
            end
            out_stall <= 1'b0;
        end
    end

    initial begin : source_side
        int                      n_sent;
        int                      next_region;
        int                      roll;
        logic [2*COORD_BITS-1:0] spot;

        rst_n        <= 1'b0;
        in_valid     <= 1'b0;
        in_item      <= '0;
        gaps_on      = 1'b1;
        stalls_on    = 1'b1;
        wide_heights = 1'b1;
        height_base  = '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // directed: absent column gives background
        send_item(make_item(MODE_READ, 9'd0, 9'd0, 12'sh000));
        // single column at the lowest height, flat region shades at base grey
        send_item(make_item(MODE_LOAD, 9'd0, 9'd0, 12'sh800));
        send_item(make_item(MODE_READ, 9'd0, 9'd0, 12'sh000));
        // far corner at the highest height, full-scale grey
        send_item(make_item(MODE_LOAD, 9'd511, 9'd511, 12'sh7FF));
        send_item(make_item(MODE_READ, 9'd511, 9'd511, 12'sh000));
        send_item(make_item(MODE_READ, 9'd0, 9'd0, 12'sh7FF));
        // midpoint and just below zero
        send_item(make_item(MODE_LOAD, 9'd511, 9'd0, 12'sh000));
        send_item(make_item(MODE_READ, 9'd511, 9'd0, 12'sh000));
        send_item(make_item(MODE_LOAD, 9'd0, 9'd511, 12'shFFF));
        send_item(make_item(MODE_READ, 9'd0, 9'd511, 12'sh000));
        // reload replaces the height but the extremes keep the old one
        send_item(make_item(MODE_LOAD, 9'd0, 9'd0, 12'sd100));
        send_item(make_item(MODE_READ, 9'd0, 9'd0, 12'sh000));
        // absent column with alternating coordinate bits
        send_item(make_item(MODE_READ, 9'h155, 9'h0AA, 12'sh555));
        // unused mode, must be ignored
        send_item(make_item(MODE_UNUSED, 9'd511, 9'd511, 12'sh800));
        send_item(make_item(MODE_READ, 9'd511, 9'd511, 12'sh000));
        // new region forgets everything
        send_item(make_item(MODE_REGION, 9'h0AA, 9'h155, 12'shAAA));
        send_item(make_item(MODE_READ, 9'd511, 9'd511, 12'sh000));
        // flat region of two equal columns, then a lower one widens the span
        send_item(make_item(MODE_LOAD, 9'd5, 9'd5, 12'sd7));
        send_item(make_item(MODE_READ, 9'd5, 9'd5, 12'sh000));
        send_item(make_item(MODE_LOAD, 9'd6, 9'd5, 12'sd7));
        send_item(make_item(MODE_READ, 9'd6, 9'd5, 12'sh000));
        send_item(make_item(MODE_LOAD, 9'd7, 9'd5, -12'sd3));
        send_item(make_item(MODE_READ, 9'd5, 9'd5, 12'sh000));
        send_item(make_item(MODE_READ, 9'd7, 9'd5, 12'sh000));

        // hold off until the directed pixels are back
        drain_results();
        coord_pool.push_back({9'd5, 9'd5});
        coord_pool.push_back({9'd6, 9'd5});
        coord_pool.push_back({9'd7, 9'd5});

        n_sent      = 0;
        next_region = $urandom_range(150, 250);
        while (n_sent < RANDOM_ITEMS) begin
            // occasionally switch idling on or off for a stretch
            if ($urandom_range(0, 99) == 0) gaps_on = ($urandom_range(0, 9) < 7);
            if ($urandom_range(0, 99) == 0) stalls_on = ($urandom_range(0, 9) < 7);
            roll = $urandom_range(0, 99);
            if (n_sent >= next_region) begin
                // sometimes let the pipeline empty before a new region
                if ($urandom_range(0, 1) == 1) drain_results();
                send_item(make_item(MODE_REGION, COORD_BITS'($urandom), COORD_BITS'($urandom),
                                    HEIGHT_BITS'($urandom)));
                coord_pool.delete();
                wide_heights = ($urandom_range(0, 2) != 0);
                height_base  = HEIGHT_BITS'($urandom);
                next_region += $urandom_range(150, 250);
                n_sent++;
            end else if (roll < 3) begin
                // noise transaction in the unused mode
                send_item(make_item(MODE_UNUSED, COORD_BITS'($urandom), COORD_BITS'($urandom),
                                    HEIGHT_BITS'($urandom)));
            end else if (roll < 45) begin
                if (coord_pool.size() > 0 &&
                    ($urandom_range(0, 3) == 0 || coord_pool.size() >= POOL_MAX)) begin
                    spot = coord_pool[$urandom_range(0, coord_pool.size() - 1)];
                end else begin
                    spot = (2*COORD_BITS)'($urandom);
                    coord_pool.push_back(spot);
                end
                send_item(make_item(MODE_LOAD, spot[2*COORD_BITS-1:COORD_BITS],
                                    spot[COORD_BITS-1:0], pick_height()));
                n_sent++;
            end else begin
                // mostly loaded columns, the rest likely absent
                if (coord_pool.size() > 0 && $urandom_range(0, 3) != 0)
                    spot = coord_pool[$urandom_range(0, coord_pool.size() - 1)];
                else
                    spot = (2*COORD_BITS)'($urandom);
                send_item(make_item(MODE_READ, spot[2*COORD_BITS-1:COORD_BITS],
                                    spot[COORD_BITS-1:0], HEIGHT_BITS'($urandom)));
                n_sent++;
            end
        end

        drain_results();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (errors == 0 && pending == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    initial begin : run_limit
        #(RUN_LIMIT_NS);
        $display("status: fail");
        $finish;
    end

endmodule
